@@ rtl/core/saoc_pkg.sv @@
// Shared types, constants and wheel decode for the synchro angle offset corrector.
package saoc_pkg;

   localparam int unsigned WordWidth  = 16;
   localparam int unsigned UnitsWidth = 17;
   localparam int unsigned HundWidth  = 18;
   localparam int unsigned ScaledWidth = 27;
   localparam int unsigned RecipShift = 32;

   // Offsets of a full turn or more clamp to one turn.
   localparam logic [HundWidth-1:0]  HundPerTurn = 18'd36000;
   localparam logic [UnitsWidth-1:0] TurnUnits   = 17'h10000;
   // units = floor((h*65536 + 18000) / 36000) = floor((h*2048 + 562) / 1125)
   localparam logic [ScaledWidth-1:0] RoundBias = 27'd562;
   localparam logic [ScaledWidth-1:0] Divisor   = 27'd1125;
   // floor(2^32 / 1125); estimate is low by at most one
   localparam logic [21:0] Recip = 22'd3817748;

   typedef struct packed {
      logic [15:0] az_synchro;
      logic [15:0] el_synchro;
      logic [15:0] az_wheel_whole;
      logic [15:0] az_wheel_frac;
      logic [15:0] el_wheel_whole;
      logic [15:0] el_wheel_frac;
   } req_type;

   typedef struct packed {
      logic [16:0] az_angle;
      logic [15:0] el_angle;
      logic [16:0] az_offset_units;
      logic [16:0] el_offset_units;
   } rsp_type;

   // Active-low BCD thumbwheels to hundredths of a degree; nibbles above 9 keep binary weight.
   function automatic logic [HundWidth-1:0] wheel_hundredths(
      input logic [15:0] whole_raw,
      input logic [15:0] frac_raw
   );
      logic [15:0] w;
      logic [15:0] f;
      logic [10:0] deg;
      logic [7:0]  hund;
      w    = ~whole_raw;
      f    = ~frac_raw;
      deg  = 11'(w[11:8]) * 11'd100 + 11'(w[7:4]) * 11'd10 + 11'(w[3:0]);
      hund = 8'(f[7:4]) * 8'd10 + 8'(f[3:0]);
      return HundWidth'(deg) * 18'd100 + HundWidth'(hund);
   endfunction

endpackage

@@ rtl/core/synchro_angle_offset_correct_unit.sv @@
// Top level: thumbwheel offset decode, scaling to angle units and synchro correction.
//
//   channel   ports                          direction   beat
//   request   req_valid req_ready req_data   in          raw angles and wheel words
//   response  rsp_valid rsp_ready rsp_data   out         corrected angles and offsets
//
// Four register stages: wheel decode, reciprocal multiply, quotient fix and clamp,
// angle add, with a 27x22 reciprocal multiply. One beat per cycle while the response is not stalled.
// Each stage loads when empty or when the stage after it moves, so bubbles close up
// and a stalled response does not block the stages behind it until they fill.
// Synchronous reset clears the valid bits only.
module synchro_angle_offset_correct_unit
   import saoc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // stage valids
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   // stage 1: hundredths
   logic [15:0]          az_syn1_ff, el_syn1_ff;
   logic [HundWidth-1:0] az_h1_ff, el_h1_ff;
   logic [HundWidth-1:0] az_h1_in, el_h1_in;

   // stage 2: quotient estimate
   logic [15:0]            az_syn2_ff, el_syn2_ff;
   logic [ScaledWidth-1:0] az_m2_ff, el_m2_ff, az_m2_in, el_m2_in;
   logic [UnitsWidth-1:0]  az_q2_ff, el_q2_ff, az_q2_in, el_q2_in;
   logic                   az_clamp2_ff, el_clamp2_ff;
   logic [48:0]            az_prod, el_prod;

   // stage 3: offset units
   logic [15:0]            az_syn3_ff, el_syn3_ff;
   logic [UnitsWidth-1:0]  az_u3_ff, el_u3_ff, az_u3_in, el_u3_in;
   logic [ScaledWidth-1:0] az_rem, el_rem;

   // stage 4: result
   rsp_type rsp_ff, rsp_in;
   logic [15:0] az_sum, el_sum;

   assign rdy4      = !v4_ff || rsp_ready;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;
   assign rsp_valid = v4_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      az_h1_in = wheel_hundredths(req_data.az_wheel_whole, req_data.az_wheel_frac);
      el_h1_in = wheel_hundredths(req_data.el_wheel_whole, req_data.el_wheel_frac);
   end

   // m = h*2048 + 562, valid when h is below a full turn
   always_comb begin
      az_m2_in = {az_h1_ff[15:0], 11'd0} + RoundBias;
      el_m2_in = {el_h1_ff[15:0], 11'd0} + RoundBias;
      az_prod  = 49'(az_m2_in) * 49'(Recip);
      el_prod  = 49'(el_m2_in) * 49'(Recip);
      az_q2_in = az_prod[RecipShift +: UnitsWidth];
      el_q2_in = el_prod[RecipShift +: UnitsWidth];
   end

   always_comb begin
      az_rem = az_m2_ff - ScaledWidth'(az_q2_ff) * Divisor;
      el_rem = el_m2_ff - ScaledWidth'(el_q2_ff) * Divisor;
      if (az_clamp2_ff) begin
         az_u3_in = TurnUnits;
      end else begin
         az_u3_in = az_q2_ff + UnitsWidth'(az_rem >= Divisor);
      end
      if (el_clamp2_ff) begin
         el_u3_in = TurnUnits;
      end else begin
         el_u3_in = el_q2_ff + UnitsWidth'(el_rem >= Divisor);
      end
   end

   // a clamped offset has zero low bits, so it adds nothing mod one turn
   always_comb begin
      az_sum                 = az_syn3_ff + az_u3_ff[15:0];
      el_sum                 = el_syn3_ff + el_u3_ff[15:0];
      rsp_in.az_angle        = TurnUnits - {1'b0, az_sum};
      rsp_in.el_angle        = el_sum;
      rsp_in.az_offset_units = az_u3_ff;
      rsp_in.el_offset_units = el_u3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_valid) begin
         az_syn1_ff <= req_data.az_synchro;
         el_syn1_ff <= req_data.el_synchro;
         az_h1_ff   <= az_h1_in;
         el_h1_ff   <= el_h1_in;
      end
      if (rdy2 && v1_ff) begin
         az_syn2_ff   <= az_syn1_ff;
         el_syn2_ff   <= el_syn1_ff;
         az_m2_ff     <= az_m2_in;
         el_m2_ff     <= el_m2_in;
         az_q2_ff     <= az_q2_in;
         el_q2_ff     <= el_q2_in;
         az_clamp2_ff <= az_h1_ff >= HundPerTurn;
         el_clamp2_ff <= el_h1_ff >= HundPerTurn;
      end
      if (rdy3 && v2_ff) begin
         az_syn3_ff <= az_syn2_ff;
         el_syn3_ff <= el_syn2_ff;
         az_u3_ff   <= az_u3_in;
         el_u3_ff   <= el_u3_in;
      end
      if (rdy4 && v3_ff) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   // reciprocal estimate must be at most one low
   a_az_est_close: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !az_clamp2_ff |-> az_rem < 2 * Divisor)
      else $error("azimuth quotient estimate off by more than one");

   a_el_est_close: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !el_clamp2_ff |-> el_rem < 2 * Divisor)
      else $error("elevation quotient estimate off by more than one");

   a_units_bound: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> az_u3_ff <= TurnUnits && el_u3_ff <= TurnUnits)
      else $error("offset units above one turn");

   a_az_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.az_angle != '0)
      else $error("reversed azimuth is zero");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted beat lost at first stage");
`endif

endmodule
